FILE: design/sdcc_pkg.sv
// ----------------------------------------------------------------------------
// sdcc_pkg
// Shared widths, register indexes, reset values and types for the bottom
// space point duplet compatibility check.
// ----------------------------------------------------------------------------
`default_nettype none

package sdcc_pkg;

    localparam int RADIUS_W   = 15;
    localparam int Z_W        = 17;
    localparam int GAP_W      = 15;
    localparam int SLOPE_W    = 16;
    localparam int ADZ_W      = 17;
    localparam int PROD_W     = RADIUS_W + SLOPE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int SLOPE_FRAC_BITS_DEF = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIDDLE_RADIUS = 3'd0,
        CFG_MIDDLE_Z      = 3'd1,
        CFG_GAP_MIN       = 3'd2,
        CFG_GAP_MAX       = 3'd3,
        CFG_SLOPE_MAX     = 3'd4,
        CFG_REGION_MIN    = 3'd5,
        CFG_REGION_MAX    = 3'd6
    } t_cfg_idx;

    localparam logic        [RADIUS_W-1:0] MIDDLE_RADIUS_RST = 15'd0;
    localparam logic signed [Z_W-1:0]      MIDDLE_Z_RST      = 17'sd0;
    localparam logic        [GAP_W-1:0]    GAP_MIN_RST       = 15'd80;
    localparam logic        [GAP_W-1:0]    GAP_MAX_RST       = 15'd960;
    localparam logic        [SLOPE_W-1:0]  SLOPE_MAX_RST     = 16'd30310;
    localparam logic signed [Z_W-1:0]      REGION_MIN_RST    = -17'sd2400;
    localparam logic signed [Z_W-1:0]      REGION_MAX_RST    = 17'sd2400;

    typedef struct packed {
        logic        [RADIUS_W-1:0] middle_radius;
        logic signed [Z_W-1:0]      middle_z;
        logic        [GAP_W-1:0]    gap_min;
        logic        [GAP_W-1:0]    gap_max;
        logic        [SLOPE_W-1:0]  slope_max;
        logic signed [Z_W-1:0]      region_min;
        logic signed [Z_W-1:0]      region_max;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic ok;
        logic neg;
    } t_tag;

endpackage

`default_nettype wire

FILE: design/sdcc_front.sv
// ----------------------------------------------------------------------------
// sdcc_front
// Entry stage: radial gap, gap window check, absolute z gap and the
// dividend for the slope division.
// ----------------------------------------------------------------------------
`default_nettype none

module sdcc_front #(
    parameter int SLOPE_FRAC_BITS = sdcc_pkg::SLOPE_FRAC_BITS_DEF,
    parameter int NUM_W           = sdcc_pkg::ADZ_W + SLOPE_FRAC_BITS
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_en,
    input  wire                                     i_valid,
    input  wire        [sdcc_pkg::RADIUS_W-1:0]     i_bottom_radius,
    input  wire signed [sdcc_pkg::Z_W-1:0]          i_bottom_z,
    input  sdcc_pkg::t_cfg                          i_cfg,
    output sdcc_pkg::t_tag                          o_tag,
    output logic       [sdcc_pkg::GAP_W-1:0]        o_div,
    output logic       [NUM_W-1:0]                  o_num
);
    import sdcc_pkg::*;

    logic                  gap_pos;
    logic [GAP_W:0]        gap;
    logic signed [Z_W:0]   dz;
    logic [ADZ_W-1:0]      adz;
    t_tag                  n_tag;
    t_tag                  r_tag;
    logic [GAP_W-1:0]      r_div;
    logic [NUM_W-1:0]      r_num;

    assign gap     = {1'b0, i_cfg.middle_radius} - {1'b0, i_bottom_radius};
    assign gap_pos = i_cfg.middle_radius > i_bottom_radius;
    assign dz      = {i_cfg.middle_z[Z_W-1], i_cfg.middle_z} - {i_bottom_z[Z_W-1], i_bottom_z};
    assign adz     = dz[Z_W] ? ADZ_W'(-dz) : ADZ_W'(dz);

    always_comb begin
        n_tag.valid = i_valid;
        n_tag.neg   = dz[Z_W];
        n_tag.ok    = gap_pos && (gap[GAP_W-1:0] >= i_cfg.gap_min)
                              && (gap[GAP_W-1:0] <= i_cfg.gap_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= gap[GAP_W-1:0];
            r_num <= {adz, {SLOPE_FRAC_BITS{1'b0}}};
        end
    end

    assign o_tag = r_tag;
    assign o_div = r_div;
    assign o_num = r_num;

endmodule

`default_nettype wire

FILE: design/sdcc_div.sv
// ----------------------------------------------------------------------------
// sdcc_div
// Pipelined restoring divider: one quotient bit per stage, giving the
// absolute slope truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sdcc_div #(
    parameter int SLOPE_FRAC_BITS = sdcc_pkg::SLOPE_FRAC_BITS_DEF,
    parameter int NUM_W           = sdcc_pkg::ADZ_W + SLOPE_FRAC_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  sdcc_pkg::t_tag                   i_tag,
    input  wire  [sdcc_pkg::GAP_W-1:0]       i_div,
    input  wire  [NUM_W-1:0]                 i_num,
    output sdcc_pkg::t_tag                   o_tag,
    output logic [NUM_W-1:0]                 o_quot
);
    import sdcc_pkg::*;

    t_tag             r_tag [NUM_W];
    logic [GAP_W-1:0] r_rem [NUM_W];
    logic [GAP_W-1:0] r_div [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        t_tag             tag_in;
        logic [GAP_W-1:0] rem_in;
        logic [GAP_W-1:0] div_in;
        logic [NUM_W-1:0] num_in;
        logic [GAP_W:0]   rem_sh;
        logic [GAP_W:0]   rem_sub;
        logic             take;

        if (k == 0) begin : g_first
            assign tag_in = i_tag;
            assign rem_in = '0;
            assign div_in = i_div;
            assign num_in = i_num;
        end else begin : g_next
            assign tag_in = r_tag[k-1];
            assign rem_in = r_rem[k-1];
            assign div_in = r_div[k-1];
            assign num_in = r_num[k-1];
        end

        assign rem_sh  = {rem_in, num_in[NUM_W-1]};
        assign take    = rem_sh >= {1'b0, div_in};
        assign rem_sub = rem_sh - {1'b0, div_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else if (i_en) begin
                r_tag[k] <= tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? rem_sub[GAP_W-1:0] : rem_sh[GAP_W-1:0];
                r_div[k] <= div_in;
                r_num[k] <= {num_in[NUM_W-2:0], take};
            end
        end
    end

    assign o_tag  = r_tag[NUM_W-1];
    assign o_quot = r_num[NUM_W-1];

endmodule

`default_nettype wire

FILE: design/sdcc_back.sv
// ----------------------------------------------------------------------------
// sdcc_back
// Slope limit, beam-line z shift, intercept and collision region check.
// Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sdcc_back #(
    parameter int SLOPE_FRAC_BITS = sdcc_pkg::SLOPE_FRAC_BITS_DEF,
    parameter int NUM_W           = sdcc_pkg::ADZ_W + SLOPE_FRAC_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  sdcc_pkg::t_tag               i_tag,
    input  wire  [NUM_W-1:0]             i_quot,
    input  sdcc_pkg::t_cfg               i_cfg,
    output sdcc_pkg::t_tag               o_tag
);
    import sdcc_pkg::*;

    localparam int SH_W  = PROD_W - SLOPE_FRAC_BITS;
    localparam int SUM_W = (SH_W + 1 > Z_W) ? SH_W + 1 : Z_W;
    localparam int IC_W  = SUM_W + 1;

    logic                   over;
    logic [SLOPE_W-1:0]     acot;
    t_tag                   n_tag_m;
    logic [PROD_W-1:0]      n_prod;
    t_tag                   r_tag_m;
    logic [PROD_W-1:0]      r_prod;

    logic [SH_W-1:0]        ashift;
    logic signed [IC_W-1:0] zm_x;
    logic signed [IC_W-1:0] sh_x;
    logic signed [IC_W-1:0] n_icpt;
    t_tag                   r_tag_i;
    logic signed [IC_W-1:0] r_icpt;

    logic signed [IC_W-1:0] rmin_x;
    logic signed [IC_W-1:0] rmax_x;
    t_tag                   n_tag_c;
    t_tag                   r_tag_c;

    // slope stage
    assign over = |i_quot[NUM_W-1:SLOPE_W];
    assign acot = i_quot[SLOPE_W-1:0];

    always_comb begin
        n_tag_m     = i_tag;
        n_tag_m.ok  = i_tag.ok && !over && (acot <= i_cfg.slope_max);
    end

    assign n_prod = PROD_W'(i_cfg.middle_radius) * PROD_W'(acot);

    // intercept stage
    assign ashift = r_prod[PROD_W-1:SLOPE_FRAC_BITS];
    assign zm_x   = IC_W'($signed(i_cfg.middle_z));
    assign sh_x   = IC_W'(ashift);
    assign n_icpt = r_tag_m.neg ? zm_x + sh_x : zm_x - sh_x;

    // region stage
    assign rmin_x = IC_W'($signed(i_cfg.region_min));
    assign rmax_x = IC_W'($signed(i_cfg.region_max));

    always_comb begin
        n_tag_c    = r_tag_i;
        n_tag_c.ok = r_tag_i.ok && (r_icpt >= rmin_x) && (r_icpt <= rmax_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_m <= '0;
            r_tag_i <= '0;
            r_tag_c <= '0;
        end else if (i_en) begin
            r_tag_m <= n_tag_m;
            r_tag_i <= r_tag_m;
            r_tag_c <= n_tag_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_icpt <= n_icpt;
        end
    end

    assign o_tag = r_tag_c;

endmodule

`default_nettype wire

FILE: design/seed_duplet_compat_check_top.sv
// Throughput: one request per cycle while the output buffer is not full; the
// slope divider resolves one quotient bit per pipeline stage, so its depth sets the latency.
// A two-entry output buffer keeps o_ready high while one result waits.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// seed_duplet_compat_check_top
// Bottom space point duplet compatibility check: configuration registers,
// pipeline and output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module seed_duplet_compat_check_top #(
    parameter int SLOPE_FRAC_BITS = sdcc_pkg::SLOPE_FRAC_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire        [sdcc_pkg::RADIUS_W-1:0]   i_bottom_radius,
    input  wire signed [sdcc_pkg::Z_W-1:0]        i_bottom_z,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic                                  o_compatible,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire        [sdcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire        [sdcc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sdcc_pkg::*;

    localparam int NUM_W = ADZ_W + SLOPE_FRAC_BITS;

    t_cfg             r_cfg;
    logic             en;
    t_tag             front_tag;
    logic [GAP_W-1:0] front_div;
    logic [NUM_W-1:0] front_num;
    t_tag             div_tag;
    logic [NUM_W-1:0] div_quot;
    t_tag             tail_tag;
    logic             push;
    logic             pop;
    logic             r_out_v;
    logic             r_out;
    logic             r_sk_v;
    logic             r_sk;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.middle_radius <= MIDDLE_RADIUS_RST;
            r_cfg.middle_z      <= MIDDLE_Z_RST;
            r_cfg.gap_min       <= GAP_MIN_RST;
            r_cfg.gap_max       <= GAP_MAX_RST;
            r_cfg.slope_max     <= SLOPE_MAX_RST;
            r_cfg.region_min    <= REGION_MIN_RST;
            r_cfg.region_max    <= REGION_MAX_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIDDLE_RADIUS: r_cfg.middle_radius <= i_cfg_data[RADIUS_W-1:0];
                CFG_MIDDLE_Z:      r_cfg.middle_z      <= $signed(i_cfg_data[Z_W-1:0]);
                CFG_GAP_MIN:       r_cfg.gap_min       <= i_cfg_data[GAP_W-1:0];
                CFG_GAP_MAX:       r_cfg.gap_max       <= i_cfg_data[GAP_W-1:0];
                CFG_SLOPE_MAX:     r_cfg.slope_max     <= i_cfg_data[SLOPE_W-1:0];
                CFG_REGION_MIN:    r_cfg.region_min    <= $signed(i_cfg_data[Z_W-1:0]);
                CFG_REGION_MAX:    r_cfg.region_max    <= $signed(i_cfg_data[Z_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // hold the whole pipeline while the buffer is full
    assign en      = !r_sk_v;
    assign o_ready = en;

    sdcc_front #(
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS),
        .NUM_W           (NUM_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_valid),
        .i_bottom_radius (i_bottom_radius),
        .i_bottom_z      (i_bottom_z),
        .i_cfg           (r_cfg),
        .o_tag           (front_tag),
        .o_div           (front_div),
        .o_num           (front_num)
    );

    sdcc_div #(
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS),
        .NUM_W           (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (front_tag),
        .i_div   (front_div),
        .i_num   (front_num),
        .o_tag   (div_tag),
        .o_quot  (div_quot)
    );

    sdcc_back #(
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS),
        .NUM_W           (NUM_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (div_tag),
        .i_quot  (div_quot),
        .i_cfg   (r_cfg),
        .o_tag   (tail_tag)
    );

    // output register with one skid entry
    assign push = en && tail_tag.valid;
    assign pop  = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (!r_out_v || pop) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end else begin
                r_out_v <= push;
            end
        end else if (push) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            r_out <= r_sk_v ? r_sk : tail_tag.ok;
        end
        if (r_out_v && !pop && push) begin
            r_sk <= tail_tag.ok;
        end
    end

    assign o_valid      = r_out_v;
    assign o_compatible = r_out;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_out_v)
        else $error("skid entry held with empty output register");

    a_skid_after_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_v) |-> $past(r_out_v && !i_ready))
        else $error("skid entry filled without an output stall");

    a_tail_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |=> $stable(tail_tag))
        else $error("pipeline advanced while the buffer was full");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_v && i_ready) |=> (r_out_v && !r_sk_v && o_compatible == $past(r_sk)))
        else $error("skid entry not moved to output register");
`endif

endmodule

`default_nettype wire

FILE: sim/seed_duplet_compat_check_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seed_duplet_compat_check_top_tb
// Self-checking bench for the duplet compatibility check. Requests are
// streamed from a pending queue under random valid and ready gaps. Every
// accepted request is scored against a local fixed-point predictor of the
// gap, slope and beam-line intercept cuts. Results are compared in order,
// over directed edge cases and several random register settings.
// ----------------------------------------------------------------------------
module seed_duplet_compat_check_top_tb;

    import sdcc_pkg::*;

    localparam int FRAC        = SLOPE_FRAC_BITS_DEF;
    localparam int LATENCY     = FRAC + 22;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct {
        logic        [RADIUS_W-1:0] radius;
        logic signed [Z_W-1:0]      z;
    } t_point;

    typedef struct {
        t_point pt;
        logic   compatible;
    } t_verdict;

    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_valid         = 1'b0;
    logic                        o_ready;
    logic        [RADIUS_W-1:0]  i_bottom_radius = '0;
    logic signed [Z_W-1:0]       i_bottom_z      = '0;
    logic                        o_valid;
    logic                        i_ready         = 1'b0;
    logic                        o_compatible;
    logic                        i_cfg_valid     = 1'b0;
    logic                        o_cfg_ready;
    logic        [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic        [CFG_DATA_W-1:0] i_cfg_data     = '0;

    t_cfg        cut_cfg;
    t_point      bottom_q[$];
    t_verdict    verdict_q[$];
    t_point      drive_pt;
    int          queued_cnt   = 0;
    int          accepted_cnt = 0;
    int          err_count    = 0;
    int unsigned cycle_count  = 0;
    bit          stall_en     = 1'b1;
    logic        req_taken    = 1'b0;

    seed_duplet_compat_check_top #(
        .SLOPE_FRAC_BITS (FRAC)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_bottom_radius (i_bottom_radius),
        .i_bottom_z      (i_bottom_z),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_compatible    (o_compatible),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic predict_duplet(t_point pt);
        longint rm, zm, gap, dz, adz, acot, shift, icpt;
        rm  = longint'(cut_cfg.middle_radius);
        zm  = longint'($signed(cut_cfg.middle_z));
        gap = rm - longint'(pt.radius);
        if (gap <= 0) begin
            return 1'b0;
        end
        dz    = zm - longint'($signed(pt.z));
        adz   = (dz < 0) ? -dz : dz;
        acot  = (adz << FRAC) / gap;
        shift = (rm * acot) >> FRAC;
        if (dz < 0) begin
            shift = -shift;
        end
        icpt = zm - shift;
        return gap >= longint'(cut_cfg.gap_min) &&
               gap <= longint'(cut_cfg.gap_max) &&
               acot <= longint'(cut_cfg.slope_max) &&
               icpt >= longint'($signed(cut_cfg.region_min)) &&
               icpt <= longint'($signed(cut_cfg.region_max));
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MIDDLE_RADIUS: cut_cfg.middle_radius = data[RADIUS_W-1:0];
            CFG_MIDDLE_Z:      cut_cfg.middle_z      = data[Z_W-1:0];
            CFG_GAP_MIN:       cut_cfg.gap_min       = data[GAP_W-1:0];
            CFG_GAP_MAX:       cut_cfg.gap_max       = data[GAP_W-1:0];
            CFG_SLOPE_MAX:     cut_cfg.slope_max     = data[SLOPE_W-1:0];
            CFG_REGION_MIN:    cut_cfg.region_min    = data[Z_W-1:0];
            CFG_REGION_MAX:    cut_cfg.region_max    = data[Z_W-1:0];
            default: ;
        endcase
    endfunction

    // Mostly points on a line from the middle point to an intercept near the region
    function automatic t_point rand_point();
        t_point pt;
        longint rm, zm, rb, zb, lo, hi, t_lo, t_hi, t;
        rm = longint'(cut_cfg.middle_radius);
        zm = longint'($signed(cut_cfg.middle_z));
        if (rm == 0 || $urandom_range(0, 99) >= 70) begin
            pt.radius = RADIUS_W'($urandom);
            pt.z      = Z_W'($urandom);
            return pt;
        end
        lo = longint'(cut_cfg.gap_min) - 8;
        hi = longint'(cut_cfg.gap_max) + 8;
        if (lo < 0) begin
            lo = 0;
        end
        rb = rm - longint'($urandom_range(int'(hi), int'(lo)));
        if (rb < 0) begin
            rb = 0;
        end
        t_lo = longint'($signed(cut_cfg.region_min));
        t_hi = longint'($signed(cut_cfg.region_max));
        if (t_lo > t_hi) begin
            t    = t_lo;
            t_lo = t_hi;
            t_hi = t;
        end
        t_lo = t_lo - 40;
        t_hi = t_hi + 40;
        t    = t_lo + longint'($urandom_range(0, int'(t_hi - t_lo)));
        zb   = t + (zm - t) * rb / rm + longint'($urandom_range(0, 6)) - 3;
        if (zb < -65536) begin
            zb = -65536;
        end
        if (zb > 65535) begin
            zb = 65535;
        end
        pt.radius = RADIUS_W'(rb);
        pt.z      = Z_W'(zb);
        return pt;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    task automatic push_point(longint r, longint z);
        t_point pt;
        pt.radius = RADIUS_W'(r);
        pt.z      = Z_W'(z);
        bottom_q.push_back(pt);
        queued_cnt++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        apply_cfg(idx, data);
    endtask

    // Unused upper data bits are filled at random to check the masking
    task automatic load_config(input longint rm, zm, gmin, gmax, smax, rmin, rmax);
        cfg_write(CFG_MIDDLE_RADIUS, {2'($urandom), RADIUS_W'(rm)});
        cfg_write(CFG_MIDDLE_Z,      Z_W'(zm));
        cfg_write(CFG_GAP_MIN,       {2'($urandom), GAP_W'(gmin)});
        cfg_write(CFG_GAP_MAX,       {2'($urandom), GAP_W'(gmax)});
        cfg_write(CFG_SLOPE_MAX,     {1'($urandom), SLOPE_W'(smax)});
        cfg_write(CFG_REGION_MIN,    Z_W'(rmin));
        cfg_write(CFG_REGION_MAX,    Z_W'(rmax));
        cfg_write(CFG_UNUSED_IDX,    CFG_DATA_W'($urandom));
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic load_random_config(bit raw);
        longint rm, gmin;
        if (raw) begin
            load_config(longint'($urandom), longint'($urandom), longint'($urandom),
                        longint'($urandom), longint'($urandom), longint'($urandom),
                        longint'($urandom));
        end else begin
            rm   = $urandom_range(2000, 32767);
            gmin = $urandom_range(0, 600);
            load_config(rm, longint'($urandom_range(0, 16000)) - 8000, gmin,
                        gmin + longint'($urandom_range(0, 6000)),
                        $urandom_range(4000, 65535),
                        -longint'($urandom_range(0, 8000)),
                        $urandom_range(0, 8000));
        end
    endtask

    task automatic drain();
        do @(negedge i_clk); while (accepted_cnt != queued_cnt || verdict_q.size() != 0);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (bottom_q.size() != 0 && !(stall_en && $urandom_range(0, 99) < 33)) begin
                drive_pt = bottom_q.pop_front();
                i_valid         <= 1'b1;
                i_bottom_radius <= drive_pt.radius;
                i_bottom_z      <= drive_pt.z;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= !(stall_en && $urandom_range(0, 99) < 33);
    end

    always @(posedge i_clk) begin : monitor
        t_verdict v;
        req_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                v.pt.radius  = i_bottom_radius;
                v.pt.z       = i_bottom_z;
                v.compatible = predict_duplet(v.pt);
                verdict_q.push_back(v);
                accepted_cnt++;
            end
            if (o_valid && i_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("result %b with no request outstanding",
                                              o_compatible));
                end else begin
                    v = verdict_q.pop_front();
                    if (o_compatible !== v.compatible) begin
                        report_mismatch($sformatf("radius %0d z %0d: compatible %b, expected %b",
                                                  v.pt.radius, v.pt.z, o_compatible,
                                                  v.compatible));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_point rp;
        cut_cfg = '{MIDDLE_RADIUS_RST, MIDDLE_Z_RST, GAP_MIN_RST, GAP_MAX_RST,
                    SLOPE_MAX_RST, REGION_MIN_RST, REGION_MAX_RST};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // reset values: middle radius zero, so the gap is never positive
        push_point(0, 0);
        push_point(32767, -65536);
        drain();

        load_config(1000, 0, 80, 960, 30310, -2400, 2400);
        push_point(920, 0);
        push_point(921, 0);
        push_point(40, 0);
        push_point(39, 0);
        push_point(500, -1200);
        push_point(500, -1201);
        push_point(500, 1200);
        drain();

        // slope limit edge with the intercept cut opened up
        load_config(1000, 0, 80, 960, 30310, -65536, 65535);
        push_point(500, -3700);
        push_point(500, -3701);
        push_point(500, 3701);
        drain();

        load_config(32767, -65536, 0, 32767, 65535, -65536, 65535);
        push_point(0, 65535);
        push_point(32766, -65536);
        push_point(32766, -65535);
        push_point(0, -65536);
        drain();

        // empty gap window
        load_config(1000, 0, 500, 400, 65535, -65536, 65535);
        push_point(550, 0);
        push_point(600, 0);
        drain();

        // empty intercept window
        load_config(1000, 0, 0, 32767, 65535, 100, -100);
        push_point(500, 0);
        drain();

        // zero-width windows and zero slope limit
        load_config(500, 0, 200, 200, 0, 0, 0);
        push_point(300, 0);
        push_point(300, 1);
        push_point(301, 0);

        for (int p = 0; p < 8; p++) begin
            drain();
            load_random_config(p == 6);
            stall_en = (p != 3);
            repeat ((p == 3) ? 150 : 55) begin
                rp = rand_point();
                push_point(rp.radius, rp.z);
            end
        end
        drain();

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
